// ===== rtl/ccsd_pkg.sv =====
// Package for the cheat code string decoder.
// Holds the letter table, the per-character and result types and the
// address descramble. No dependencies.
package ccsd_pkg;

  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [3:0] CountDash = 4'd4;
  localparam logic [3:0] CountMax  = 4'd10;
  localparam logic [3:0] LenSubst  = 4'd9;
  localparam logic [3:0] LenHex    = 4'd8;

  localparam logic KindSubst = 1'b0;
  localparam logic KindHex   = 1'b1;

  typedef struct packed {
    logic       ok;
    logic [3:0] nib;
  } nibble_t;

  typedef struct packed {
    logic    is_dash;
    nibble_t subst;
    nibble_t hex;
  } char_info_t;

  typedef struct packed {
    logic        valid;
    logic        kind;
    logic [23:0] addr;
    logic [7:0]  value;
  } result_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h61 && c <= 8'h7A) begin
      r = c - 8'd32;
    end
    return r;
  endfunction

  // letter table "DF4709156BC8A23E"
  function automatic nibble_t subst_lookup(input logic [7:0] c);
    nibble_t r;
    r.ok = 1'b1;
    unique case (c)
      8'h44:   r.nib = 4'h0;
      8'h46:   r.nib = 4'h1;
      8'h34:   r.nib = 4'h2;
      8'h37:   r.nib = 4'h3;
      8'h30:   r.nib = 4'h4;
      8'h39:   r.nib = 4'h5;
      8'h31:   r.nib = 4'h6;
      8'h35:   r.nib = 4'h7;
      8'h36:   r.nib = 4'h8;
      8'h42:   r.nib = 4'h9;
      8'h43:   r.nib = 4'hA;
      8'h38:   r.nib = 4'hB;
      8'h41:   r.nib = 4'hC;
      8'h32:   r.nib = 4'hD;
      8'h33:   r.nib = 4'hE;
      8'h45:   r.nib = 4'hF;
      default: begin
        r.ok  = 1'b0;
        r.nib = 4'h0;
      end
    endcase
    return r;
  endfunction

  function automatic nibble_t hex_lookup(input logic [7:0] c);
    nibble_t r;
    r.ok  = 1'b0;
    r.nib = 4'h0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.ok  = 1'b1;
      r.nib = c[3:0];
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r.ok  = 1'b1;
      r.nib = c[3:0] + 4'd9;
    end
    return r;
  endfunction

  function automatic logic [23:0] descramble(input logic [31:0] r);
    return {r[13:10], r[5:2], r[23:20], r[1:0], r[15:14], r[19:16], r[9:6]};
  endfunction

endpackage

// ===== rtl/cheat_code_string_decoder.sv =====
// Top level of the cheat code string decoder: handshake and result register.
// Depends on ccsd_pkg, ccsd_char_decode and ccsd_accum.
//
// Takes one character per cycle; a string of N characters gives its single
// result in the cycle after its last character is transferred, held in an
// output register. The input stalls only while that register is full and
// not being taken; otherwise a new character is accepted every cycle,
// as the accumulator updates its state on every accepted character.
module cheat_code_string_decoder import ccsd_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  character_i,
  input  logic        last_char_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic        code_valid_o,
  output logic        code_kind_o,
  output logic [23:0] target_address_o,
  output logic [7:0]  patch_value_o
);

  char_info_t info;
  result_t    res, res_q;
  logic       out_valid_q, out_valid_d;
  logic       accept;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  ccsd_char_decode u_decode (
    .character_i (character_i),
    .info_o      (info)
  );

  ccsd_accum u_accum (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (accept),
    .last_i (last_char_i),
    .info_i (info),
    .res_o  (res)
  );

  always_comb begin
    out_valid_d = out_valid_q;
    if (accept && last_char_i) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept && last_char_i) begin
      res_q <= res;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign code_valid_o     = res_q.valid;
  assign code_kind_o      = res_q.kind;
  assign target_address_o = res_q.addr;
  assign patch_value_o    = res_q.value;

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  a_last_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_char_i) |=> out_valid_o)
    else $error("last character transfer gave no result");

  a_no_spurious_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_o && !(in_valid_i && in_ready_o && last_char_i)) |=> !out_valid_o)
    else $error("result appeared without a last character");

  a_reject_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !code_valid_o) |->
      (!code_kind_o && target_address_o == 24'd0 && patch_value_o == 8'd0))
    else $error("rejected string carries non-zero fields");

endmodule

// ===== rtl/ccsd_char_decode.sv =====
// Character classifier: case fold, dash detection, letter table and hex digit lookup.
// Depends on ccsd_pkg.
module ccsd_char_decode import ccsd_pkg::*; (
  input  logic [7:0] character_i,
  output char_info_t info_o
);

  logic [7:0] folded;

  always_comb begin
    folded         = fold_case(character_i);
    info_o.is_dash = (folded == CharDash);
    info_o.subst   = subst_lookup(folded);
    info_o.hex     = hex_lookup(folded);
  end

endmodule

// ===== rtl/ccsd_accum.sv =====
// String state: count, dash flag, both accumulators and error flags, plus the
// end-of-string result decision. Depends on ccsd_pkg.
module ccsd_accum import ccsd_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic       last_i,
  input  char_info_t info_i,
  output result_t    res_o
);

  logic [3:0]  count_q, count_d;
  logic [31:0] sub_acc_q, sub_acc_d;
  logic [31:0] hex_acc_q, hex_acc_d;
  logic        sub_bad_q, sub_bad_d;
  logic        hex_bad_q, hex_bad_d;
  logic        dash_q, dash_d;

  always_comb begin
    count_d   = (count_q < CountMax) ? count_q + 4'd1 : count_q;
    dash_d    = dash_q | ((count_q == CountDash) & info_i.is_dash);
    sub_acc_d = sub_acc_q;
    sub_bad_d = sub_bad_q;
    if (!info_i.is_dash) begin
      if (info_i.subst.ok) begin
        sub_acc_d = {sub_acc_q[27:0], info_i.subst.nib};
      end else begin
        sub_bad_d = 1'b1;
      end
    end
    hex_acc_d = hex_acc_q;
    hex_bad_d = hex_bad_q;
    if (info_i.hex.ok) begin
      hex_acc_d = {hex_acc_q[27:0], info_i.hex.nib};
    end else begin
      hex_bad_d = 1'b1;
    end

    res_o = '0;
    if (count_d == LenSubst && dash_d) begin
      if (!sub_bad_d) begin
        res_o.valid = 1'b1;
        res_o.kind  = KindSubst;
        res_o.addr  = descramble(sub_acc_d);
        res_o.value = sub_acc_d[31:24];
      end
    end else if (count_d == LenHex) begin
      if (!hex_bad_d) begin
        res_o.valid = 1'b1;
        res_o.kind  = KindHex;
        res_o.addr  = hex_acc_d[31:8];
        res_o.value = hex_acc_d[7:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q   <= '0;
      sub_acc_q <= '0;
      hex_acc_q <= '0;
      sub_bad_q <= 1'b0;
      hex_bad_q <= 1'b0;
      dash_q    <= 1'b0;
    end else if (step_i) begin
      if (last_i) begin
        count_q   <= '0;
        sub_acc_q <= '0;
        hex_acc_q <= '0;
        sub_bad_q <= 1'b0;
        hex_bad_q <= 1'b0;
        dash_q    <= 1'b0;
      end else begin
        count_q   <= count_d;
        sub_acc_q <= sub_acc_d;
        hex_acc_q <= hex_acc_d;
        sub_bad_q <= sub_bad_d;
        hex_bad_q <= hex_bad_d;
        dash_q    <= dash_d;
      end
    end
  end

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for cheat_code_string_decoder: character strings in,
// decoded cheat results checked against a local predictor of the decoder.
// Depends on ccsd_pkg and the decoder RTL only.
module testbench import ccsd_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [127:0] GG_LETTERS = "DF4709156BC8A23E";
  localparam logic [127:0] HEX_DIGITS = "0123456789ABCDEF";
  localparam int TAIL_ITEMS = 150;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    logic       hold;
  } char_xfer_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_ready_o;
  logic [7:0]  character_i = 8'h00;
  logic        last_char_i = 1'b0;
  logic        out_valid_o;
  logic        out_ready_i = 1'b0;
  logic        code_valid_o;
  logic        code_kind_o;
  logic [23:0] target_address_o;
  logic [7:0]  patch_value_o;

  char_xfer_t char_q[$];
  logic [7:0] code_chars[$];
  result_t    code_result_q[$];
  result_t    want;
  logic       taken = 1'b0;
  int         gap_left = 0;
  int         stall_left = 0;
  int         err_cnt = 0;

  logic [3:0]  seen_cnt = '0;
  logic [31:0] gg_acc = '0;
  logic [31:0] hex_acc = '0;
  logic        gg_bad = 1'b0;
  logic        hex_bad = 1'b0;
  logic        dash_fifth = 1'b0;

  cheat_code_string_decoder dut (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .character_i,
    .last_char_i,
    .out_valid_o,
    .out_ready_i,
    .code_valid_o,
    .code_kind_o,
    .target_address_o,
    .patch_value_o
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic logic [4:0] gg_nibble(input logic [7:0] c);
    for (int i = 0; i < 16; i++) begin
      if (GG_LETTERS[127 - 8 * i -: 8] == c) begin
        return {1'b1, 4'(i)};
      end
    end
    return 5'b0;
  endfunction

  function automatic logic [4:0] hex_nibble(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
    end else begin
      return 5'b0;
    end
    return {1'b1, d[3:0]};
  endfunction

  task automatic decode_char(input logic [7:0] raw, input logic last);
    logic [7:0]  c;
    logic [4:0]  gn;
    logic [4:0]  hn;
    logic [31:0] s;
    logic [31:0] a;
    result_t     r;
    c = raw;
    if (c >= "a" && c <= "z") begin
      c = c - 8'd32;
    end
    if (seen_cnt == CountDash && c == CharDash) begin
      dash_fifth = 1'b1;
    end
    if (c != CharDash) begin
      gn = gg_nibble(c);
      if (!gn[4]) begin
        gg_bad = 1'b1;
      end else begin
        gg_acc = {gg_acc[27:0], gn[3:0]};
      end
    end
    hn = hex_nibble(c);
    if (!hn[4]) begin
      hex_bad = 1'b1;
    end else begin
      hex_acc = {hex_acc[27:0], hn[3:0]};
    end
    if (seen_cnt < CountMax) begin
      seen_cnt = seen_cnt + 4'd1;
    end
    if (last) begin
      r = '0;
      if (seen_cnt == LenSubst && dash_fifth) begin
        if (!gg_bad) begin
          s = gg_acc;
          a = ((s & 32'h3C00) << 10) | ((s & 32'h3C) << 14) | ((s & 32'hF00000) >> 8) |
              ((s & 32'h3) << 10) | ((s & 32'hC000) >> 6) | ((s & 32'hF0000) >> 12) |
              ((s & 32'h3C0) >> 6);
          r.valid = 1'b1;
          r.kind  = KindSubst;
          r.addr  = a[23:0];
          r.value = s[31:24];
        end
      end else if (seen_cnt == LenHex && !hex_bad) begin
        r.valid = 1'b1;
        r.kind  = KindHex;
        r.addr  = hex_acc[31:8];
        r.value = hex_acc[7:0];
      end
      code_result_q.insert(code_result_q.size(), r);
      seen_cnt   = '0;
      gg_acc     = '0;
      hex_acc    = '0;
      gg_bad     = 1'b0;
      hex_bad    = 1'b0;
      dash_fifth = 1'b0;
    end
  endtask

  function automatic logic [7:0] rand_case(input logic [7:0] c);
    if (c >= "A" && c <= "Z" && $urandom_range(0, 1) == 1) begin
      return c + 8'd32;
    end
    return c;
  endfunction

  function automatic logic [7:0] gg_char();
    return rand_case(GG_LETTERS[8 * $urandom_range(0, 15) +: 8]);
  endfunction

  function automatic logic [7:0] hex_char();
    return rand_case(HEX_DIGITS[8 * $urandom_range(0, 15) +: 8]);
  endfunction

  task automatic add_char(input logic [7:0] c);
    code_chars.insert(code_chars.size(), c);
  endtask

  task automatic flush_code(input logic hold);
    int n;
    n = code_chars.size();
    for (int i = 0; i < n; i++) begin
      char_q.insert(char_q.size(),
                    '{ch: code_chars[i], last: (i == n - 1), hold: (hold && i == 0)});
    end
    code_chars.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) begin
      add_char(s[i]);
    end
    flush_code(1'b0);
  endtask

  // sender: hold valid until the transfer, then advance or idle
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !taken) begin
      in_valid_i <= 1'b1;
    end else if (gap_left != 0) begin
      gap_left   <= gap_left - 1;
      in_valid_i <= 1'b0;
    end else if (char_q.size() == 0 || (char_q[0].hold && code_result_q.size() != 0)) begin
      in_valid_i <= 1'b0;
    end else if (char_q.size() > TAIL_ITEMS && $urandom_range(0, 7) == 0) begin
      gap_left   <= $urandom_range(0, 2);
      in_valid_i <= 1'b0;
    end else begin
      in_valid_i  <= 1'b1;
      character_i <= char_q[0].ch;
      last_char_i <= char_q[0].last;
    end
  end

  always @(posedge clk_i) begin
    taken <= rst_ni && in_valid_i && in_ready_o;
    if (rst_ni && in_valid_i && in_ready_o) begin
      decode_char(character_i, last_char_i);
      void'(char_q.pop_front());
    end
  end

  always @(negedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (stall_left != 0) begin
      stall_left  <= stall_left - 1;
      out_ready_i <= 1'b0;
    end else if (char_q.size() > TAIL_ITEMS && $urandom_range(0, 5) == 0) begin
      stall_left  <= $urandom_range(0, 2);
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (code_result_q.size() == 0) begin
        $display("%0t: result with none expected: valid %0b kind %0b addr %06h value %02h",
                 $time, code_valid_o, code_kind_o, target_address_o, patch_value_o);
        err_cnt++;
      end else begin
        want = code_result_q.pop_front();
        if (code_valid_o !== want.valid) begin
          $display("%0t: code_valid expected %0b actual %0b", $time, want.valid, code_valid_o);
          err_cnt++;
        end
        if (code_kind_o !== want.kind) begin
          $display("%0t: code_kind expected %0b actual %0b", $time, want.kind, code_kind_o);
          err_cnt++;
        end
        if (target_address_o !== want.addr) begin
          $display("%0t: target_address expected %06h actual %06h",
                   $time, want.addr, target_address_o);
          err_cnt++;
        end
        if (patch_value_o !== want.value) begin
          $display("%0t: patch_value expected %02h actual %02h",
                   $time, want.value, patch_value_o);
          err_cnt++;
        end
      end
    end
  end

  initial begin
    int kind;
    int len;
    int strings;
    add_text("dF47-09e5");
    add_text("Ab0123fF");
    add_text("DF47-0-15");
    add_char(8'h00);
    add_char(8'hFF);
    flush_code(1'b0);
    strings = 0;
    while (char_q.size() < 1600) begin
      kind = $urandom_range(0, 19);
      if (kind < 8 || kind == 15) begin
        for (int i = 0; i < 9; i++) begin
          add_char(i == 4 ? CharDash : gg_char());
        end
        if ($urandom_range(0, 9) == 0) begin
          code_chars[$urandom_range(0, 8)] = CharDash;
        end
      end else if (kind < 17) begin
        for (int i = 0; i < 8; i++) begin
          add_char(hex_char());
        end
      end else begin
        len = $urandom_range(1, 14);
        for (int i = 0; i < len; i++) begin
          case ($urandom_range(0, 3))
            0: add_char(8'($urandom_range(0, 255)));
            1: add_char(gg_char());
            2: add_char(hex_char());
            default: add_char(CharDash);
          endcase
        end
      end
      if (kind == 15 || kind == 16) begin
        case ($urandom_range(0, 2))
          0: code_chars[$urandom_range(0, code_chars.size() - 1)] = 8'($urandom_range(0, 255));
          1: void'(code_chars.pop_back());
          default: add_char(gg_char());
        endcase
      end
      flush_code(strings == 0 || strings == 120);
      strings++;
    end
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    while (char_q.size() != 0 || code_result_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (8) @(posedge clk_i);
    if (err_cnt == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #3_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
